// File: hw/rtl/cfd_pkg.sv
`default_nettype none
package cfd_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int REPORT_BITS = 16;
   localparam logic [7:0] CODE_RUN_MAX = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef logic [LENGTH_BITS-1:0] count_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
   } item_type;

   typedef struct packed {
      logic                   valid;
      logic [7:0]             out_byte;
      logic                   frame_done;
      logic [REPORT_BITS-1:0] frame_length;
   } result_type;

   function automatic logic [REPORT_BITS-1:0] sat_length(input count_type count);
      logic [LENGTH_BITS+REPORT_BITS-1:0] wide;
      logic [LENGTH_BITS+REPORT_BITS-1:0] limit;
      wide  = {{REPORT_BITS{1'b0}}, count};
      limit = {{LENGTH_BITS{1'b0}}, {REPORT_BITS{1'b1}}};
      if (wide > limit) begin
         return {REPORT_BITS{1'b1}};
      end
      return wide[REPORT_BITS-1:0];
   endfunction

   function automatic count_type bump_count(input count_type count);
      if (count == {LENGTH_BITS{1'b1}}) begin
         return count;
      end
      return count + count_type'(1);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cobs_frame_decoder_unit.sv
// COBS frame decoder: one received byte per item in, one decoded byte or
// end-of-frame marker per result out.
// Input channel: req_valid / req_stall with req_in_byte. The first byte of a
// frame is taken as the opening delimiter and dropped; a zero in a code
// position closes the frame.
// Result channel: rsp_valid / rsp_stall with rsp_out_byte, rsp_frame_done
// and rsp_frame_length. The end marker has rsp_frame_done set, a zero byte
// and the decoded length, saturated at 0xFFFF.
// Path: an accepted byte sits in the input register and is decoded into the
// result register, which drives the rsp_ ports.
// Throughput: one byte per cycle unless rsp_stall holds a pending result; the
// opening delimiter and code bytes without a separating zero give no result.
// Reset: synchronous; clears the valid bits of both registers and returns the
// decoder to waiting for an opening byte.
// Stall: while rsp_stall holds a pending result, the result register and the
// byte in the input register hold, and req_stall rises once that input
// register is occupied.
`default_nettype none
module cobs_frame_decoder_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_in_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_frame_done,
   output logic [cfd_pkg::REPORT_BITS-1:0]       rsp_frame_length
);
   import cfd_pkg::*;

   item_type   item;
   result_type res;
   logic       advance;

   cfd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .item        (item)
   );

   cfd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .res     (res)
   );

   cfd_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .res              (res),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule
`default_nettype wire

// File: hw/rtl/cfd_in_reg.sv
`default_nettype none
module cfd_in_reg (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_in_byte,
   input  wire logic          advance,
   output cfd_pkg::item_type  item
);
   import cfd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.in_byte = byte_ff;

endmodule
`default_nettype wire

// File: hw/rtl/cfd_decode.sv
`default_nettype none
module cfd_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfd_pkg::item_type   item,
   input  wire logic                advance,
   output cfd_pkg::result_type      res
);
   import cfd_pkg::*;

   logic       in_frame_ff;
   logic       in_frame_in;
   logic [7:0] group_left_ff;
   logic [7:0] group_left_in;
   logic       skip_zero_ff;
   logic       skip_zero_in;
   count_type  count_ff;
   count_type  count_in;
   logic       commit;

   assign commit = item.valid && advance;

   always_comb begin
      in_frame_in   = in_frame_ff;
      group_left_in = group_left_ff;
      skip_zero_in  = skip_zero_ff;
      count_in      = count_ff;
      res           = '0;
      if (item.valid) begin
         priority if (!in_frame_ff) begin
            in_frame_in   = 1'b1;
            group_left_in = BYTE_ZERO;
            skip_zero_in  = 1'b1;
            count_in      = '0;
         end else if (group_left_ff != BYTE_ZERO) begin
            group_left_in = group_left_ff - 8'd1;
            count_in      = bump_count(count_ff);
            res.valid     = 1'b1;
            res.out_byte  = item.in_byte;
         end else if (item.in_byte == BYTE_ZERO) begin
            in_frame_in      = 1'b0;
            group_left_in    = BYTE_ZERO;
            skip_zero_in     = 1'b1;
            count_in         = '0;
            res.valid        = 1'b1;
            res.frame_done   = 1'b1;
            res.frame_length = sat_length(count_ff);
         end else begin
            group_left_in = item.in_byte - 8'd1;
            skip_zero_in  = (item.in_byte == CODE_RUN_MAX);
            if (!skip_zero_ff) begin
               count_in  = bump_count(count_ff);
               res.valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         group_left_ff <= BYTE_ZERO;
         skip_zero_ff  <= 1'b1;
         count_ff      <= '0;
      end else if (commit) begin
         in_frame_ff   <= in_frame_in;
         group_left_ff <= group_left_in;
         skip_zero_ff  <= skip_zero_in;
         count_ff      <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/cfd_out_reg.sv
`default_nettype none
module cfd_out_reg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire cfd_pkg::result_type              res,
   output logic                                  advance,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_frame_done,
   output logic [cfd_pkg::REPORT_BITS-1:0]       rsp_frame_length
);
   import cfd_pkg::*;

   logic                   valid_ff;
   logic [7:0]             byte_ff;
   logic                   done_ff;
   logic [REPORT_BITS-1:0] length_ff;

   assign advance = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.valid) begin
         byte_ff   <= res.out_byte;
         done_ff   <= res.frame_done;
         length_ff <= res.frame_length;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_frame_done   = done_ff;
   assign rsp_frame_length = length_ff;

endmodule
`default_nettype wire

// File: hw/rtl/cfd_checker.sv
`default_nettype none
module cfd_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [7:0]                 rsp_out_byte,
   input wire logic                       rsp_frame_done,
   input wire logic [cfd_pkg::REPORT_BITS-1:0] rsp_frame_length
);
   import cfd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_frame_done) && $stable(rsp_frame_length))
      else $error("result changed while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without an accepted byte");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_done ? rsp_out_byte == BYTE_ZERO
                                    : rsp_frame_length == '0))
      else $error("result fields inconsistent");

endmodule

bind cobs_frame_decoder_unit cfd_checker u_cfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_frame_length (rsp_frame_length)
);
`default_nettype wire

// File: tb/sv/tb_cobs_frame_decoder_unit.sv
`timescale 1ns / 1ps
module tb_cobs_frame_decoder_unit;

   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam longint unsigned REPORT_MAX = (64'd1 << cfd_pkg::REPORT_BITS) - 1;

   typedef struct packed {
      logic [7:0]                      out_byte;
      logic                            frame_done;
      logic [cfd_pkg::REPORT_BITS-1:0] frame_length;
   } decoded_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_frame_done;
   logic [cfd_pkg::REPORT_BITS-1:0] rsp_frame_length;

   decoded_result_type pending_results[$];
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   logic hold_trigger = 1'b0;
   logic hold_seen = 1'b0;
   int unsigned hold_count = 0;

   logic dec_in_frame = 1'b0;
   logic [7:0] dec_group_left = 8'h00;
   logic dec_skip_zero = 1'b1;
   cfd_pkg::count_type dec_count = '0;

   cobs_frame_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_length (rsp_frame_length)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void push_result(input logic [7:0] b, input logic done,
                                       input logic [cfd_pkg::REPORT_BITS-1:0] len);
      decoded_result_type r;
      r.out_byte     = b;
      r.frame_done   = done;
      r.frame_length = len;
      pending_results.push_back(r);
   endfunction

   function automatic void count_decoded();
      if (dec_count != {cfd_pkg::LENGTH_BITS{1'b1}}) begin
         dec_count = dec_count + 1'b1;
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      longint unsigned len;
      if (!dec_in_frame) begin
         dec_in_frame   = 1'b1;
         dec_group_left = 8'h00;
         dec_skip_zero  = 1'b1;
         dec_count      = '0;
      end else if (dec_group_left != 8'h00) begin
         dec_group_left = dec_group_left - 8'h01;
         count_decoded();
         push_result(b, 1'b0, '0);
      end else if (b == cfd_pkg::BYTE_ZERO) begin
         len = 64'(dec_count);
         if (len > REPORT_MAX) begin
            len = REPORT_MAX;
         end
         push_result(cfd_pkg::BYTE_ZERO, 1'b1, cfd_pkg::REPORT_BITS'(len));
         dec_in_frame   = 1'b0;
         dec_group_left = 8'h00;
         dec_skip_zero  = 1'b1;
         dec_count      = '0;
      end else begin
         if (!dec_skip_zero) begin
            count_decoded();
            push_result(cfd_pkg::BYTE_ZERO, 1'b0, '0);
         end
         dec_group_left = b - 8'h01;
         dec_skip_zero  = (b == cfd_pkg::CODE_RUN_MAX);
      end
   endfunction

   always @(posedge clock) begin
      if (hold_count > 0) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count - 1;
      end else if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_count <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      decoded_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected item: out_byte %0h frame_done %0b frame_length %0d",
                   rsp_out_byte, rsp_frame_done, rsp_frame_length);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, actual %0h", want.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_frame_done !== want.frame_done) begin
               $error("frame_done: expected %0b, actual %0b",
                      want.frame_done, rsp_frame_done);
               error_count++;
            end
            if (rsp_frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, actual %0d",
                      want.frame_length, rsp_frame_length);
               error_count++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do begin
         @(posedge clock);
      end while (req_stall);
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic sync_to_idle();
      while (dec_in_frame) begin
         send_byte(cfd_pkg::BYTE_ZERO);
      end
   endtask

   function automatic logic [7:0] random_data();
      if ($urandom_range(99) < 15) begin
         return cfd_pkg::BYTE_ZERO;
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic send_random_frame(input int unsigned n_groups);
      int unsigned pick;
      logic [7:0] code;
      send_byte(($urandom_range(99) < 90) ? cfd_pkg::BYTE_ZERO : 8'($urandom_range(255)));
      repeat (n_groups) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            code = cfd_pkg::CODE_RUN_MAX;
         end else if (pick < 14) begin
            code = 8'h01;
         end else begin
            code = 8'($urandom_range(2, 16));
         end
         send_byte(code);
         repeat (int'(code) - 1) send_byte(random_data());
      end
      send_byte(cfd_pkg::BYTE_ZERO);
   endtask

   task automatic send_noise(input int unsigned n);
      repeat (n) begin
         send_byte(($urandom_range(99) < 30) ? cfd_pkg::BYTE_ZERO : 8'($urandom_range(255)));
      end
   endtask

   task automatic test_directed_frames();
      sync_to_idle();
      // empty groups, zero and all-ones inside a group
      send_byte(cfd_pkg::BYTE_ZERO);
      send_byte(8'h01);
      send_byte(8'h01);
      send_byte(8'h03);
      send_byte(cfd_pkg::BYTE_ZERO);
      send_byte(8'hFF);
      send_byte(cfd_pkg::BYTE_ZERO);
      // nonzero opening byte, separating zero between groups
      send_byte(8'hA5);
      send_byte(8'h02);
      send_byte(8'h80);
      send_byte(8'h02);
      send_byte(8'h7F);
      send_byte(cfd_pkg::BYTE_ZERO);
      // empty frames
      send_byte(cfd_pkg::BYTE_ZERO);
      send_byte(cfd_pkg::BYTE_ZERO);
      send_byte(8'hFF);
      send_byte(cfd_pkg::BYTE_ZERO);
   endtask

   task automatic test_random_traffic(input int unsigned n_bytes);
      int unsigned start_count;
      start_count = bytes_sent;
      while (bytes_sent - start_count < n_bytes) begin
         if ($urandom_range(99) < 85) begin
            send_random_frame($urandom_range(0, 6));
         end else begin
            send_noise($urandom_range(1, 8));
         end
      end
   endtask

   task automatic test_input_backpressure();
      sync_to_idle();
      hold_trigger <= ~hold_trigger;
      send_byte(cfd_pkg::BYTE_ZERO);
      send_byte(8'h30);
      repeat (47) send_byte(random_data());
      send_byte(cfd_pkg::BYTE_ZERO);
   endtask

   task automatic test_long_frame();
      sync_to_idle();
      send_byte(cfd_pkg::BYTE_ZERO);
      repeat (2) begin
         send_byte(cfd_pkg::CODE_RUN_MAX);
         repeat (254) send_byte(8'($urandom_range(255)));
      end
      send_byte(cfd_pkg::BYTE_ZERO);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 85;
      test_directed_frames();
      test_random_traffic(600);
      wait_for_idle();

      send_idle_pct = 85;
      recv_idle_pct = 8;
      test_random_traffic(600);
      wait_for_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_input_backpressure();
      test_random_traffic(400);
      test_long_frame();
      wait_for_idle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_in_reg.sv
hw/rtl/cfd_decode.sv
hw/rtl/cfd_out_reg.sv
hw/rtl/cobs_frame_decoder_unit.sv
hw/rtl/cfd_checker.sv
tb/sv/tb_cobs_frame_decoder_unit.sv
